// ----- design/assert_macros.svh -----
// Assertion macros shared by the design files.
// No dependencies; compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    `ASSERT_CLK(lbl, clk, rstn, !(expr))

`else

`define ASSERT_CLK(lbl, clk, rstn, prop)

`define ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

// ----- design/gsa_pkg.sv -----
// Package for the generational slot allocator: operation and status codes,
// default sizes and field widths. No dependencies.
package gsa_pkg;

    localparam int GSA_SLOTS    = 64;
    localparam int GSA_GEN_BITS = 16;

    // fixed widths of the beat fields
    localparam int IDX_FIELD_W = 6;
    localparam int GEN_FIELD_W = 16;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 32;

    typedef enum logic [1:0] {
        OP_ALLOC    = 2'd0,
        OP_FREE     = 2'd1,
        OP_CHECK    = 2'd2,
        OP_FREE_ALL = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_STALE = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

endpackage

// ----- design/generational_slot_allocator.sv -----
// Generational slot allocator. Each input beat is allocate, free, check or
// free-all, and each gives exactly one result beat. Slot state ({occupied,
// generation}) and the LIFO free stack (index plus the generation the slot
// will be handed out with) live in two memories with registered reads.
// Allocate, free and check: the accept cycle issues the memory reads and
// the next cycle evaluates, writes back and loads the result register, so
// no new beat is taken while one is being evaluated. Free-all walks the
// opened slots through the slot memory's single read port, alternating a
// read state and an evaluate state for each slot. No clearing pass: entries
// are only used below the opened-slot count or the free-stack depth.
// Depends on gsa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module generational_slot_allocator
    import gsa_pkg::*;
#(
    parameter int SLOTS    = GSA_SLOTS,
    parameter int GEN_BITS = GSA_GEN_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [1:0] operation, [7:2] slot_index, [23:8] generation
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [5:0] handle_index, [21:6] handle_generation, [22] running,
    // [24:23] status, [31:25] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = IW + 1;
    localparam int GW    = GEN_BITS;
    localparam int CMPW  = (CNT_W > IDX_FIELD_W) ? CNT_W : IDX_FIELD_W;
    localparam int CW    = (GW > GEN_FIELD_W) ? GW : GEN_FIELD_W;
    localparam int SWW   = GW + 1;
    localparam int STW   = GW + IW;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_WRD,
        S_WEV
    } t_state;

    function automatic logic [GW-1:0] f_next_gen(input logic [GW-1:0] g);
        logic [GW-1:0] n;
        n = g + GW'(1);
        if (n == '0) begin
            n = GW'(1);
        end
        return n;
    endfunction

    // memories
    logic [SWW-1:0] r_slot_mem  [SLOTS];
    logic [STW-1:0] r_stack_mem [SLOTS];
    logic [SWW-1:0] r_slot_rd;
    logic [STW-1:0] r_stack_rd;

    // control and payload registers
    t_state                 r_state, n_state;
    t_op                    r_op, n_op;
    logic [IDX_FIELD_W-1:0] r_idx, n_idx;
    logic [GEN_FIELD_W-1:0] r_gen, n_gen;
    logic [CNT_W-1:0]       r_opened, n_opened;
    logic [CNT_W-1:0]       r_free_depth, n_free_depth;
    logic [IW-1:0]          r_walk, n_walk;
    logic                   r_run, n_run;
    logic                   r_out_valid, n_out_valid;
    logic [IDX_FIELD_W-1:0] r_out_idx, n_out_idx;
    logic [GEN_FIELD_W-1:0] r_out_gen, n_out_gen;
    logic                   r_out_run, n_out_run;
    t_status                r_out_st, n_out_st;

    // memory ports
    logic           slot_we;
    logic [IW-1:0]  slot_wa;
    logic [SWW-1:0] slot_wd;
    logic [IW-1:0]  slot_ra;
    logic           stack_we;
    logic [IW-1:0]  stack_wa;
    logic [STW-1:0] stack_wd;
    logic [IW-1:0]  stack_ra;

    // decode and compare
    logic                   in_accept;
    logic [IDX_FIELD_W-1:0] in_idx;
    logic [CMPW-1:0]        in_idx_ext;
    logic [CMPW-1:0]        r_idx_ext;
    logic [CNT_W-1:0]       depth_m1;
    logic                   slot_occ;
    logic [GW-1:0]          slot_gen;
    logic [GW-1:0]          slot_gen_nxt;
    logic                   cur;
    logic [IW-1:0]          pop_idx;
    logic [GW-1:0]          pop_gen;
    logic [CMPW-1:0]        sel_idx_ext;
    logic [CW-1:0]          sel_gen_ext;
    logic                   walk_last;

    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign in_idx     = s_axis_tdata[7:2];
    assign in_idx_ext = CMPW'(in_idx);
    assign r_idx_ext  = CMPW'(r_idx);
    assign depth_m1   = r_free_depth - CNT_W'(1);
    assign stack_ra   = depth_m1[IW-1:0];
    assign slot_ra    = (r_state == S_IDLE) ? in_idx_ext[IW-1:0] : r_walk;

    assign slot_occ     = r_slot_rd[GW];
    assign slot_gen     = r_slot_rd[GW-1:0];
    assign slot_gen_nxt = f_next_gen(slot_gen);
    assign cur          = (r_idx_ext < CMPW'(r_opened)) && (CW'(r_gen) == CW'(slot_gen));
    assign pop_idx      = r_stack_rd[IW-1:0];
    assign pop_gen      = r_stack_rd[STW-1:IW];
    assign walk_last    = (CNT_W'(r_walk) + CNT_W'(1)) == r_opened;

    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || m_axis_tready);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_st, r_out_run, r_out_gen, r_out_idx};

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_idx        = r_idx;
        n_gen        = r_gen;
        n_opened     = r_opened;
        n_free_depth = r_free_depth;
        n_walk       = r_walk;
        n_run        = r_run;
        n_out_valid  = r_out_valid;
        n_out_idx    = r_out_idx;
        n_out_gen    = r_out_gen;
        n_out_run    = r_out_run;
        n_out_st     = r_out_st;
        slot_we      = 1'b0;
        slot_wa      = r_walk;
        slot_wd      = {1'b0, slot_gen_nxt};
        stack_we     = 1'b0;
        stack_wa     = r_free_depth[IW-1:0];
        stack_wd     = {slot_gen_nxt, r_walk};
        sel_idx_ext  = '0;
        sel_gen_ext  = '0;

        if (m_axis_tvalid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_op    = t_op'(s_axis_tdata[1:0]);
                    n_idx   = in_idx;
                    n_gen   = s_axis_tdata[23:8];
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_out_idx = r_idx;
                n_out_gen = r_gen;
                n_out_run = cur;
                n_out_st  = ST_OK;
                n_state   = S_IDLE;
                unique case (r_op)
                    OP_ALLOC: begin
                        n_out_run   = 1'b0;
                        n_out_valid = 1'b1;
                        if (r_free_depth != '0) begin
                            // reuse the most recently freed slot
                            sel_idx_ext  = CMPW'(pop_idx);
                            sel_gen_ext  = CW'(pop_gen);
                            slot_we      = 1'b1;
                            slot_wa      = pop_idx;
                            slot_wd      = {1'b1, pop_gen};
                            n_free_depth = depth_m1;
                            n_out_idx    = sel_idx_ext[IDX_FIELD_W-1:0];
                            n_out_gen    = sel_gen_ext[GEN_FIELD_W-1:0];
                        end else if (r_opened < CNT_W'(SLOTS)) begin
                            // open a fresh slot at generation one
                            sel_idx_ext = CMPW'(r_opened);
                            slot_we     = 1'b1;
                            slot_wa     = r_opened[IW-1:0];
                            slot_wd     = {1'b1, GW'(1)};
                            n_opened    = r_opened + CNT_W'(1);
                            n_out_idx   = sel_idx_ext[IDX_FIELD_W-1:0];
                            n_out_gen   = GEN_FIELD_W'(1);
                        end else begin
                            n_out_idx = '0;
                            n_out_gen = '0;
                            n_out_st  = ST_FULL;
                        end
                    end
                    OP_FREE: begin
                        n_out_valid = 1'b1;
                        if (!cur) begin
                            n_out_st = ST_STALE;
                        end else if (!slot_occ) begin
                            n_out_st = ST_EMPTY;
                        end else begin
                            slot_we  = 1'b1;
                            slot_wa  = r_idx_ext[IW-1:0];
                            stack_wd = {slot_gen_nxt, r_idx_ext[IW-1:0]};
                            if (r_free_depth < CNT_W'(SLOTS)) begin
                                stack_we     = 1'b1;
                                n_free_depth = r_free_depth + CNT_W'(1);
                            end
                        end
                    end
                    OP_CHECK: begin
                        n_out_valid = 1'b1;
                    end
                    OP_FREE_ALL: begin
                        // running reflects the handle before the walk
                        n_run  = cur;
                        n_walk = '0;
                        if (r_opened == '0) begin
                            n_out_valid = 1'b1;
                        end else begin
                            n_state = S_WRD;
                        end
                    end
                    default: begin
                        n_out_valid = 1'b1;
                    end
                endcase
            end
            S_WRD: begin
                n_state = S_WEV;
            end
            S_WEV: begin
                if (slot_occ) begin
                    slot_we = 1'b1;
                    if (r_free_depth < CNT_W'(SLOTS)) begin
                        stack_we     = 1'b1;
                        n_free_depth = r_free_depth + CNT_W'(1);
                    end
                end
                if (walk_last) begin
                    n_out_idx   = r_idx;
                    n_out_gen   = r_gen;
                    n_out_run   = r_run;
                    n_out_st    = ST_OK;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_walk  = r_walk + IW'(1);
                    n_state = S_WRD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_opened     <= '0;
            r_free_depth <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_opened     <= n_opened;
            r_free_depth <= n_free_depth;
            r_out_valid  <= n_out_valid;
        end
        r_op      <= n_op;
        r_idx     <= n_idx;
        r_gen     <= n_gen;
        r_walk    <= n_walk;
        r_run     <= n_run;
        r_out_idx <= n_out_idx;
        r_out_gen <= n_out_gen;
        r_out_run <= n_out_run;
        r_out_st  <= n_out_st;
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            r_slot_mem[slot_wa] <= slot_wd;
        end
        r_slot_rd <= r_slot_mem[slot_ra];
    end

    always_ff @(posedge i_clk) begin
        if (stack_we) begin
            r_stack_mem[stack_wa] <= stack_wd;
        end
        r_stack_rd <= r_stack_mem[stack_ra];
    end

    `ASSERT_CLK(a_depth_le_open, i_clk, i_rst_n, r_free_depth <= r_opened)
    `ASSERT_CLK(a_open_le_slots, i_clk, i_rst_n, r_opened <= CNT_W'(SLOTS))
    `ASSERT_CLK(a_load_on_empty, i_clk, i_rst_n, (r_state == S_EVAL && r_op != OP_FREE_ALL) |-> !r_out_valid)
    `ASSERT_CLK(a_walk_bound, i_clk, i_rst_n, (r_state == S_WRD) |-> (CNT_W'(r_walk) < r_opened))
    `ASSERT_CLK(a_accept_eval, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready) |=> (r_state == S_EVAL))
    `ASSERT_NEVER(a_no_dual_push, i_clk, i_rst_n, stack_we && !slot_we)

endmodule
